// ----- hw/rtl/vertical_blend_deinterlace_assert.svh -----
// Assertion macros shared by the vertical blend deinterlacer RTL.
`ifndef VERTICAL_BLEND_DEINTERLACE_ASSERT_SVH
`define VERTICAL_BLEND_DEINTERLACE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define VBD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vertical_blend_deinterlace: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define VBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vertical_blend_deinterlace: next-cycle check failed");

`endif

// ----- hw/rtl/vbd_pkg.sv -----
// Types, constants and helper functions for the vertical blend deinterlacer.
package vbd_pkg;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int SAMPLE_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RESET   = 13'd720;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  typedef logic [SAMPLE_W-1:0]  sample_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;
  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  typedef struct packed {
    sample_t sample;
  } in_beat_t;

  typedef struct packed {
    sample_t blended;
    logic    last_of_run;
    logic    end_of_frame;
  } out_beat_t;

  function automatic sample_t avg_up(input sample_t x, input sample_t y);
    logic [SAMPLE_W:0] sum;
    sum = {1'b0, x} + {1'b0, y} + (SAMPLE_W+1)'(1);
    return sum[SAMPLE_W:1];
  endfunction

  function automatic sample_t avg_down(input sample_t x, input sample_t y);
    logic [SAMPLE_W:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    return sum[SAMPLE_W:1];
  endfunction

endpackage

// ----- hw/rtl/vbd_stream_if.sv -----
// Valid/ready stream interface carrying one payload beat.
interface vbd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/vbd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module vbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- hw/rtl/vertical_blend_deinterlace.sv -----
// Each result is formed in stage s1 from its completing sample, then registered for output.
// Output for input row r appears while row r+1 streams in; row 0 yields no result.
// Throughput: one sample per cycle while the output register can take beats.
// Each last-row sample emits two beats through one output register, stalling the input.
// Reset clears the counters and the pipeline and loads line_width 720 and frame_height 480.
// The two line stores are not cleared; each entry is written before its read data is used.
`include "vertical_blend_deinterlace_assert.svh"

module vertical_blend_deinterlace #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  vbd_pkg::cfg_index_t cfg_index,
  input  vbd_pkg::cfg_data_t  cfg_data,
  vbd_stream_if.sink          pixels,
  vbd_stream_if.source        results
);
  import vbd_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  typedef struct packed {
    logic row_first;
    logic row_second;
    logic final_row;
    logic final_col;
  } pos_t;

  cfg_data_t  line_width;
  cfg_data_t  frame_height;
  logic [COL_W-1:0] width_m1;
  logic [ROW_W-1:0] height_m1;

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic             at_final_col;
  logic             at_final_row;

  logic             s1_valid;
  logic             s1_phase;
  sample_t          s1_sample;
  logic [COL_W-1:0] s1_col;
  pos_t             s1_pos;

  logic             fwd_valid;
  logic [COL_W-1:0] fwd_addr;
  sample_t          fwd_one;
  sample_t          fwd_two;

  sample_t one_rdata;
  sample_t two_rdata;
  sample_t prev;
  sample_t prev2;
  sample_t first_value;
  sample_t second_value;

  logic      out_valid;
  out_beat_t out_payload;
  out_beat_t emit_beat;

  logic accept;
  logic out_load;
  logic emit;
  logic s1_done;
  logic fwd_hit;

  always_comb begin
    if (line_width == '0) begin
      width_m1 = '0;
    end else if (32'(line_width) > MAX_WIDTH) begin
      width_m1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      width_m1 = COL_W'(line_width - CFG_W'(1));
    end
    if (frame_height < CFG_W'(2)) begin
      height_m1 = ROW_W'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      height_m1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      height_m1 = ROW_W'(frame_height - CFG_W'(1));
    end
  end

  assign at_final_col = (column_count == width_m1);
  assign at_final_row = (row_count == height_m1);

  assign out_load = !out_valid || results.ready;
  assign emit     = s1_valid && !s1_pos.row_first && out_load;
  assign s1_done  = s1_valid && (s1_pos.row_first ||
                                 (out_load && (s1_phase || !s1_pos.final_row)));
  assign pixels.ready = !s1_valid || s1_done;
  assign accept   = pixels.valid && pixels.ready;

  // Column and row of the next sample; a line_width or frame_height write restarts the plane.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= LINE_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_WIDTH: begin
          line_width   <= cfg_data;
          column_count <= '0;
          row_count    <= '0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data;
          column_count <= '0;
          row_count    <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (at_final_col) begin
        column_count <= '0;
        row_count    <= at_final_row ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  vbd_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_WIDTH)
  ) u_row_one_back (
    .clk  (clk),
    .we   (s1_done),
    .waddr(s1_col),
    .wdata(s1_sample),
    .re   (accept),
    .raddr(column_count),
    .rdata(one_rdata)
  );

  vbd_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_WIDTH)
  ) u_row_two_back (
    .clk  (clk),
    .we   (s1_done),
    .waddr(s1_col),
    .wdata(prev),
    .re   (accept),
    .raddr(column_count),
    .rdata(two_rdata)
  );

  // The last write-back wins over a read issued at the same edge to the same column.
  assign fwd_hit = fwd_valid && (fwd_addr == s1_col);
  assign prev    = fwd_hit ? fwd_one : one_rdata;
  assign prev2   = fwd_hit ? fwd_two : two_rdata;

  assign second_value = avg_up(prev, s1_sample);
  assign first_value  = s1_pos.row_second ? second_value
                                          : avg_up(avg_down(prev2, s1_sample), prev);

  always_comb begin
    if (s1_phase) begin
      emit_beat.blended      = second_value;
      emit_beat.last_of_run  = 1'b1;
      emit_beat.end_of_frame = s1_pos.final_col;
    end else begin
      emit_beat.blended      = first_value;
      emit_beat.last_of_run  = !s1_pos.final_row;
      emit_beat.end_of_frame = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_phase  <= 1'b0;
      fwd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end
      if (s1_done) begin
        s1_phase <= 1'b0;
      end else if (emit) begin
        s1_phase <= 1'b1;
      end
      if (s1_done) begin
        fwd_valid <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample         <= pixels.payload.sample;
      s1_col            <= column_count;
      s1_pos.row_first  <= (row_count == '0);
      s1_pos.row_second <= (row_count == ROW_W'(1));
      s1_pos.final_row  <= at_final_row;
      s1_pos.final_col  <= at_final_col;
    end
    if (s1_done) begin
      fwd_addr <= s1_col;
      fwd_one  <= s1_sample;
      fwd_two  <= prev;
    end
    if (emit) begin
      out_payload <= emit_beat;
    end
  end

  assign results.valid   = out_valid;
  assign results.payload = out_payload;

  `VBD_ASSERT_NOW(a_phase_only_last_row, clk, rst, s1_valid && s1_phase, s1_pos.final_row)
  `VBD_ASSERT_NOW(a_eof_is_last, clk, rst, out_valid && out_payload.end_of_frame,
                  out_payload.last_of_run)
  `VBD_ASSERT_NEXT(a_row_wrap_col, clk, rst, accept && at_final_col && !cfg_we,
                   column_count == '0)
  `VBD_ASSERT_NOW(a_accept_frees_stage, clk, rst, accept && s1_valid, s1_done)
endmodule
